>>> rtl/dror_pkg.sv
package dror_pkg;

	// field widths
	localparam int unsigned SAMPLE_W  = 24;
	localparam int unsigned TICK_W    = 32;
	localparam int unsigned PENDING_W = 7;

	// command codes
	typedef enum logic [1:0] {
		KIND_PUSH     = 2'd0,
		KIND_POP_RAW  = 2'd1,
		KIND_POP_ALGO = 2'd2,
		KIND_RESET    = 2'd3
	} kind_t;

endpackage

>>> rtl/dual_reader_overwrite_ring.sv
// latency: a result strobes on done in the cycle after its command is accepted
// throughput: one command per cycle, busy is always low; the ring memory has a single read
// port, and the pointer registers are updated once per accepted command
// reset: arst_n clears the write and both read pointers, the latest sample and done;
// the sample and tick memories are not cleared and need no clearing pass
module dual_reader_overwrite_ring #(
	parameter int unsigned RING_DEPTH = 128
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         kind,
	input  logic [dror_pkg::SAMPLE_W-1:0]      sample_in,
	input  logic [dror_pkg::TICK_W-1:0]        tick_in,
	output logic                               done,
	output logic                               popped,
	output logic [dror_pkg::PENDING_W-1:0]     pending,
	output logic [dror_pkg::SAMPLE_W-1:0]      sample_out,
	output logic [dror_pkg::TICK_W-1:0]        tick_out,
	output logic [dror_pkg::SAMPLE_W-1:0]      latest_sample,
	output logic                               raw_dropped,
	output logic                               algo_dropped
);

	localparam int unsigned AW = $clog2(RING_DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);
	localparam logic [AW-1:0] DEPTH_MOD = AW'(RING_DEPTH);

	// ring storage
	logic [dror_pkg::SAMPLE_W-1:0] sample_mem [RING_DEPTH];
	logic [dror_pkg::TICK_W-1:0]   tick_mem   [RING_DEPTH];

	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] raw_ptr_q;
	logic [AW-1:0] algo_ptr_q;
	logic [dror_pkg::SAMPLE_W-1:0] latest_q;

	logic [dror_pkg::SAMPLE_W-1:0] rd_sample_q;
	logic [dror_pkg::TICK_W-1:0]   rd_tick_q;

	logic                          done_s1;
	logic                          popped_s1;
	logic [dror_pkg::PENDING_W-1:0] pending_s1;
	logic                          raw_drop_s1;
	logic                          algo_drop_s1;

	logic                          accept;
	dror_pkg::kind_t               kind_c;
	logic [AW-1:0]                 wr_ptr_d;
	logic [AW-1:0]                 raw_ptr_d;
	logic [AW-1:0]                 algo_ptr_d;
	logic [AW-1:0]                 rd_addr;
	logic [AW-1:0]                 wr_next;
	logic [AW-1:0]                 cnt_c;
	logic                          push_c;
	logic                          popped_c;
	logic                          raw_drop_c;
	logic                          algo_drop_c;
	logic [dror_pkg::PENDING_W-1:0] pending_c;

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
		return (p == LAST_SLOT) ? '0 : p + AW'(1);
	endfunction

	// entries between a reader and the writer, modulo the depth
	function automatic logic [AW-1:0] ring_count(input logic [AW-1:0] wp,
		input logic [AW-1:0] rp);
		return (wp >= rp) ? (wp - rp) : (wp - rp + DEPTH_MOD);
	endfunction

	assign accept = start & ~busy;
	assign busy   = 1'b0;
	assign kind_c = dror_pkg::kind_t'(kind);

	// pointer update and result fields for one command
	always_comb begin
		wr_ptr_d    = wr_ptr_q;
		raw_ptr_d   = raw_ptr_q;
		algo_ptr_d  = algo_ptr_q;
		wr_next     = ring_next(wr_ptr_q);
		cnt_c       = '0;
		push_c      = 1'b0;
		popped_c    = 1'b0;
		raw_drop_c  = 1'b0;
		algo_drop_c = 1'b0;
		pending_c   = '0;
		rd_addr     = (kind_c == dror_pkg::KIND_POP_ALGO) ? algo_ptr_q : raw_ptr_q;
		unique case (kind_c)
			dror_pkg::KIND_PUSH: begin
				push_c   = 1'b1;
				wr_ptr_d = wr_next;
				if (algo_ptr_q == wr_next) begin
					algo_ptr_d  = ring_next(algo_ptr_q);
					algo_drop_c = 1'b1;
				end
				if (raw_ptr_q == wr_next) begin
					raw_ptr_d  = ring_next(raw_ptr_q);
					raw_drop_c = 1'b1;
				end
				cnt_c     = ring_count(wr_next, raw_ptr_d);
				pending_c = dror_pkg::PENDING_W'(cnt_c);
			end
			dror_pkg::KIND_POP_RAW: begin
				cnt_c     = ring_count(wr_ptr_q, raw_ptr_q);
				pending_c = dror_pkg::PENDING_W'(cnt_c);
				if (cnt_c != '0) begin
					popped_c  = 1'b1;
					raw_ptr_d = ring_next(raw_ptr_q);
				end
			end
			dror_pkg::KIND_POP_ALGO: begin
				cnt_c     = ring_count(wr_ptr_q, algo_ptr_q);
				pending_c = dror_pkg::PENDING_W'(cnt_c);
				if (cnt_c != '0) begin
					popped_c   = 1'b1;
					algo_ptr_d = ring_next(algo_ptr_q);
				end
			end
			dror_pkg::KIND_RESET: begin
				raw_ptr_d  = wr_ptr_q;
				algo_ptr_d = wr_ptr_q;
			end
		endcase
	end

	// control state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			raw_ptr_q  <= '0;
			algo_ptr_q <= '0;
			latest_q   <= '0;
			done_s1    <= 1'b0;
		end else begin
			done_s1 <= accept;
			if (accept) begin
				wr_ptr_q   <= wr_ptr_d;
				raw_ptr_q  <= raw_ptr_d;
				algo_ptr_q <= algo_ptr_d;
				if (push_c) begin
					latest_q <= sample_in;
				end
			end
		end
	end

	// result payload of the beat
	always_ff @(posedge clk) begin
		popped_s1    <= accept & popped_c;
		pending_s1   <= pending_c;
		raw_drop_s1  <= accept & raw_drop_c;
		algo_drop_s1 <= accept & algo_drop_c;
	end

	// memory write port
	always_ff @(posedge clk) begin
		if (accept && push_c) begin
			sample_mem[wr_ptr_q] <= sample_in;
			tick_mem[wr_ptr_q]   <= tick_in;
		end
	end

	// memory read port, registered data
	always_ff @(posedge clk) begin
		rd_sample_q <= sample_mem[rd_addr];
		rd_tick_q   <= tick_mem[rd_addr];
	end

	assign done          = done_s1;
	assign popped        = popped_s1;
	assign pending       = pending_s1;
	assign sample_out    = popped_s1 ? rd_sample_q : '0;
	assign tick_out      = popped_s1 ? rd_tick_q : '0;
	assign latest_sample = latest_q;
	assign raw_dropped   = raw_drop_s1;
	assign algo_dropped  = algo_drop_s1;

`ifndef ASSERT_OFF
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q <= LAST_SLOT) && (raw_ptr_q <= LAST_SLOT) && (algo_ptr_q <= LAST_SLOT))
		else $error("ring pointer out of range");

	a_popped_done: assert property (@(posedge clk) disable iff (!arst_n)
		popped |-> done)
		else $error("popped without result strobe");

	a_drop_push: assert property (@(posedge clk) disable iff (!arst_n)
		(raw_dropped || algo_dropped) |-> $past(accept && (kind_c == dror_pkg::KIND_PUSH)))
		else $error("drop flag without a push");

	a_reset_join: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (kind_c == dror_pkg::KIND_RESET)) |=>
		((raw_ptr_q == wr_ptr_q) && (algo_ptr_q == wr_ptr_q)))
		else $error("readers not at writer after reset command");
`endif

endmodule
